/* rtl/shf_pkg.sv */
// ----------------------------------------------------------------------------
// shf_pkg: shared definitions for the session handshake state machine
// Event codes, disconnect causes, register indexes and the result bundle
// passed from the state machine to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package shf_pkg;

  // timeout counter width and configuration register geometry
  localparam int TIMER_BITS   = 20;
  localparam int CFG_BITS     = 20;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_BITS-1:0] CONNECT_TMO_RESET = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0] CONTEXT_TMO_RESET = CFG_BITS'(1000);

  // session events
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SETUP      = 3'd1,
    OP_CONN_RESP  = 3'd2,
    OP_CTX_SETUP  = 3'd3,
    OP_CTX_READY  = 3'd4,
    OP_PEER_DISC  = 3'd5,
    OP_LOCAL_DISC = 3'd6
  } op_t;

  // reasons for entering the disconnected state
  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_VERSION  = 3'd1,
    CAUSE_LOCAL    = 3'd2,
    CAUSE_PEER     = 3'd3,
    CAUSE_CONN_TMO = 3'd4,
    CAUSE_CTX_TMO  = 3'd5
  } cause_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CONNECT_TMO = 2'd0,
    REG_CONTEXT_TMO = 2'd1
  } reg_idx_t;

  // one result transaction
  typedef struct packed {
    logic [2:0] status;
    logic       send_connect;
    logic       send_disconnect;
    logic       send_context_setup;
    logic       notify_connected;
    logic       notify_context_ready;
    logic       notify_disconnected;
    cause_t     cause;
  } result_t;

endpackage

`default_nettype wire

/* rtl/shf_fsm.sv */
// ----------------------------------------------------------------------------
// shf_fsm: session state and timeout counter
// Holds the six-state session status and the one-shot timeout counter, and
// computes the result of the current event combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module shf_fsm (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            ev_valid,
  input  wire logic [2:0]                      op,
  input  wire logic                            version_ok,
  input  wire logic [shf_pkg::CFG_BITS-1:0]    connect_ticks,
  input  wire logic [shf_pkg::CFG_BITS-1:0]    context_ticks,
  output shf_pkg::result_t                     res
);

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_WAIT_CONN = 3'd1,
    ST_CONNECTED = 3'd2,
    ST_WAIT_CTX  = 3'd3,
    ST_READY     = 3'd4,
    ST_DISC      = 3'd5
  } state_t;

  state_t                            st_r, st_nxt;
  logic [shf_pkg::TIMER_BITS-1:0]    rem_r, rem_nxt;
  logic                              armed_r, armed_nxt;
  logic                              fired;
  logic [shf_pkg::TIMER_BITS-1:0]    connect_load;
  logic [shf_pkg::TIMER_BITS-1:0]    context_load;

  assign connect_load = shf_pkg::TIMER_BITS'(connect_ticks);
  assign context_load = shf_pkg::TIMER_BITS'(context_ticks);

  // next state, timer and result for the event
  always_comb begin
    st_nxt    = st_r;
    rem_nxt   = rem_r;
    armed_nxt = armed_r;
    fired     = 1'b0;
    res       = '0;

    // countdown on tick
    if (st_r != ST_DISC && op == shf_pkg::OP_TICK && armed_r) begin
      if (rem_r <= shf_pkg::TIMER_BITS'(1)) begin
        rem_nxt   = '0;
        armed_nxt = 1'b0;
        fired     = 1'b1;
      end else begin
        rem_nxt = rem_r - shf_pkg::TIMER_BITS'(1);
      end
    end

    case (st_r)
      ST_IDLE: begin
        if (op == shf_pkg::OP_SETUP) begin
          if (!version_ok) begin
            st_nxt                  = ST_DISC;
            armed_nxt               = 1'b0;
            rem_nxt                 = '0;
            res.send_disconnect     = 1'b1;
            res.notify_disconnected = 1'b1;
            res.cause               = shf_pkg::CAUSE_VERSION;
          end else begin
            st_nxt           = ST_WAIT_CONN;
            rem_nxt          = connect_load;
            armed_nxt        = 1'b1;
            res.send_connect = 1'b1;
          end
        end else if (op == shf_pkg::OP_LOCAL_DISC) begin
          st_nxt                  = ST_DISC;
          armed_nxt               = 1'b0;
          rem_nxt                 = '0;
          res.send_disconnect     = 1'b1;
          res.notify_disconnected = 1'b1;
          res.cause               = shf_pkg::CAUSE_LOCAL;
        end
      end
      ST_WAIT_CONN: begin
        if (op == shf_pkg::OP_CONN_RESP) begin
          st_nxt               = ST_CONNECTED;
          armed_nxt            = 1'b0;
          rem_nxt              = '0;
          res.notify_connected = 1'b1;
        end else if (fired) begin
          st_nxt                  = ST_DISC;
          armed_nxt               = 1'b0;
          rem_nxt                 = '0;
          res.notify_disconnected = 1'b1;
          res.cause               = shf_pkg::CAUSE_CONN_TMO;
        end
      end
      ST_CONNECTED: begin
        if (op == shf_pkg::OP_CTX_SETUP) begin
          st_nxt                 = ST_WAIT_CTX;
          rem_nxt                = context_load;
          armed_nxt              = 1'b1;
          res.send_context_setup = 1'b1;
        end else if (op == shf_pkg::OP_LOCAL_DISC) begin
          st_nxt                  = ST_DISC;
          armed_nxt               = 1'b0;
          rem_nxt                 = '0;
          res.send_disconnect     = 1'b1;
          res.notify_disconnected = 1'b1;
          res.cause               = shf_pkg::CAUSE_LOCAL;
        end else if (op == shf_pkg::OP_PEER_DISC) begin
          st_nxt                  = ST_DISC;
          armed_nxt               = 1'b0;
          rem_nxt                 = '0;
          res.notify_disconnected = 1'b1;
          res.cause               = shf_pkg::CAUSE_PEER;
        end
      end
      ST_WAIT_CTX: begin
        if (fired) begin
          st_nxt                  = ST_DISC;
          armed_nxt               = 1'b0;
          rem_nxt                 = '0;
          res.notify_disconnected = 1'b1;
          res.cause               = shf_pkg::CAUSE_CTX_TMO;
        end else if (op == shf_pkg::OP_CTX_SETUP) begin
          rem_nxt                = context_load;
          armed_nxt              = 1'b1;
          res.send_context_setup = 1'b1;
        end else if (op == shf_pkg::OP_CTX_READY) begin
          st_nxt                   = ST_READY;
          armed_nxt                = 1'b0;
          rem_nxt                  = '0;
          res.notify_context_ready = 1'b1;
        end else if (op == shf_pkg::OP_PEER_DISC) begin
          st_nxt                  = ST_DISC;
          armed_nxt               = 1'b0;
          rem_nxt                 = '0;
          res.notify_disconnected = 1'b1;
          res.cause               = shf_pkg::CAUSE_PEER;
        end else if (op == shf_pkg::OP_LOCAL_DISC) begin
          st_nxt                  = ST_DISC;
          armed_nxt               = 1'b0;
          rem_nxt                 = '0;
          res.send_disconnect     = 1'b1;
          res.notify_disconnected = 1'b1;
          res.cause               = shf_pkg::CAUSE_LOCAL;
        end
      end
      ST_READY: begin
        if (op == shf_pkg::OP_CTX_SETUP) begin
          st_nxt                 = ST_WAIT_CTX;
          rem_nxt                = context_load;
          armed_nxt              = 1'b1;
          res.send_context_setup = 1'b1;
        end else if (op == shf_pkg::OP_PEER_DISC) begin
          st_nxt                  = ST_DISC;
          armed_nxt               = 1'b0;
          rem_nxt                 = '0;
          res.notify_disconnected = 1'b1;
          res.cause               = shf_pkg::CAUSE_PEER;
        end else if (op == shf_pkg::OP_LOCAL_DISC) begin
          st_nxt                  = ST_DISC;
          armed_nxt               = 1'b0;
          rem_nxt                 = '0;
          res.send_disconnect     = 1'b1;
          res.notify_disconnected = 1'b1;
          res.cause               = shf_pkg::CAUSE_LOCAL;
        end
      end
      default: begin
        st_nxt = st_r;
      end
    endcase

    res.status = st_nxt;
  end

  // state and timer registers, advanced once per accepted event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      rem_r   <= '0;
      armed_r <= 1'b0;
    end else if (ev_valid) begin
      st_r    <= st_nxt;
      rem_r   <= rem_nxt;
      armed_r <= armed_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/session_handshake_fsm_unit.sv */
// A result is registered in the main output entry, or in the skid entry while the main one is held.
// Throughput: one event per cycle while the input is not stalled; the session state and
// timeout counter are updated in the same cycle the event is accepted.
// A two-entry output stage (main register plus skid register) keeps the input
// open while one result waits; the input stalls only when both entries are full.
// Reset (synchronous, active low): idle session, timer disarmed, both timeouts 1000.
// ----------------------------------------------------------------------------
// session_handshake_fsm_unit: session handshake top level
// Configuration registers, the session state machine and the output stage
// with a skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module session_handshake_fsm_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [shf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [shf_pkg::CFG_BITS-1:0]        cfg_data,
  // event input
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [2:0]                          in_operation,
  input  wire logic                                in_version_ok,
  // result output
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [2:0]                          out_status,
  output      logic                                out_send_connect,
  output      logic                                out_send_disconnect,
  output      logic                                out_send_context_setup,
  output      logic                                out_notify_connected,
  output      logic                                out_notify_context_ready,
  output      logic                                out_notify_disconnected,
  output      logic [2:0]                          out_disconnect_cause
);

  logic [shf_pkg::CFG_BITS-1:0] connect_tmo_r;
  logic [shf_pkg::CFG_BITS-1:0] context_tmo_r;
  logic                         in_accept;
  logic                         out_take;
  shf_pkg::result_t             step_res;
  shf_pkg::result_t             main_r;
  shf_pkg::result_t             skid_r;
  logic                         main_valid_r;
  logic                         skid_valid_r;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_take  = main_valid_r && !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      connect_tmo_r <= shf_pkg::CONNECT_TMO_RESET;
      context_tmo_r <= shf_pkg::CONTEXT_TMO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        shf_pkg::REG_CONNECT_TMO: connect_tmo_r <= cfg_data;
        shf_pkg::REG_CONTEXT_TMO: context_tmo_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // session state machine
  shf_fsm u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .ev_valid      (in_accept),
    .op            (in_operation),
    .version_ok    (in_version_ok),
    .connect_ticks (connect_tmo_r),
    .context_ticks (context_tmo_r),
    .res           (step_res)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        main_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_accept) begin
      if (!main_valid_r || out_take) begin
        main_r       <= step_res;
        main_valid_r <= 1'b1;
      end else begin
        skid_r       <= step_res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      main_valid_r <= 1'b0;
    end
  end

  assign out_valid                = main_valid_r;
  assign out_status               = main_r.status;
  assign out_send_connect         = main_r.send_connect;
  assign out_send_disconnect      = main_r.send_disconnect;
  assign out_send_context_setup   = main_r.send_context_setup;
  assign out_notify_connected     = main_r.notify_connected;
  assign out_notify_context_ready = main_r.notify_context_ready;
  assign out_notify_disconnected  = main_r.notify_disconnected;
  assign out_disconnect_cause     = main_r.cause;

endmodule

`default_nettype wire

/* rtl/shf_checker.sv */
// ----------------------------------------------------------------------------
// shf_checker: port-level checks for the session handshake unit
// Watches the result channel for strobe, status and cause consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module shf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic [2:0] out_status,
  input wire logic       out_notify_connected,
  input wire logic       out_notify_context_ready,
  input wire logic       out_notify_disconnected,
  input wire logic [2:0] out_disconnect_cause
);

  localparam logic [2:0] STATUS_CONNECTED = 3'd2;
  localparam logic [2:0] STATUS_READY     = 3'd4;
  localparam logic [2:0] STATUS_DISC      = 3'd5;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a cause is reported exactly with the disconnect notification
  a_cause_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_disconnect_cause != shf_pkg::CAUSE_NONE) == out_notify_disconnected))
    else $error("disconnect cause and notification disagree");

  // disconnect notification lands in the disconnected status
  a_disc_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_notify_disconnected) |-> (out_status == STATUS_DISC))
    else $error("disconnect notified outside disconnected status");

  // connected notification lands in the connected status
  a_conn_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_notify_connected) |-> (out_status == STATUS_CONNECTED))
    else $error("connected notified with wrong status");

  // ready notification lands in the ready status
  a_ready_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_notify_context_ready) |-> (out_status == STATUS_READY))
    else $error("context ready notified with wrong status");

endmodule

bind session_handshake_fsm_unit shf_checker u_shf_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .out_valid                (out_valid),
  .out_status               (out_status),
  .out_notify_connected     (out_notify_connected),
  .out_notify_context_ready (out_notify_context_ready),
  .out_notify_disconnected  (out_notify_disconnected),
  .out_disconnect_cause     (out_disconnect_cause)
);

`default_nettype wire

/* tb/sv/session_handshake_fsm_unit_tb.sv */
// ----------------------------------------------------------------------------
// session_handshake_fsm_unit_tb: self-checking bench for the session handshake
// A scripted opening walks the session through every live state and ignored
// event. Random events follow, mostly well-formed, under several timeout
// settings. Every result is compared field by field against a behavioral
// model of the session and its timeout counter.
// ----------------------------------------------------------------------------
`default_nettype none

module session_handshake_fsm_unit_tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SCRIPT_LEN   = 24;
  localparam int PHASES       = 7;
  localparam int PHASE_EVENTS = 200;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 60;

  // event code outside the defined set, and a register index nobody decodes
  localparam logic [2:0]                       OP_RESERVED = 3'd7;
  localparam logic [shf_pkg::CFG_IDX_BITS-1:0] REG_UNUSED  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE      = 3'd0,
    S_WAIT_CONN = 3'd1,
    S_CONNECTED = 3'd2,
    S_WAIT_CTX  = 3'd3,
    S_READY     = 3'd4,
    S_DISC      = 3'd5
  } session_t;

  // one row of the opening script; res only counts when typed is set
  typedef struct packed {
    logic [2:0]       op;
    logic             ver;
    logic             typed;
    shf_pkg::result_t res;
  } row_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_we;
  logic [shf_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [shf_pkg::CFG_BITS-1:0]     cfg_data;
  logic                             in_valid;
  logic                             in_stall;
  logic [2:0]                       in_operation;
  logic                             in_version_ok;
  logic                             out_valid;
  logic                             out_stall;
  logic [2:0]                       out_status;
  logic                             out_send_connect;
  logic                             out_send_disconnect;
  logic                             out_send_context_setup;
  logic                             out_notify_connected;
  logic                             out_notify_context_ready;
  logic                             out_notify_disconnected;
  logic [2:0]                       out_disconnect_cause;

  // model state and configuration
  session_t                       sess;
  logic [shf_pkg::TIMER_BITS-1:0] tmr_left;
  logic                           tmr_on;
  logic [shf_pkg::CFG_BITS-1:0]   connect_tmo;
  logic [shf_pkg::CFG_BITS-1:0]   context_tmo;

  shf_pkg::result_t pending_results[$];
  logic             failed = 1'b0;
  logic             tx_gaps;
  logic             rx_gaps;
  int               events_in = 0;
  int               cycles = 0;

  // opening script: ignored events in every live state and the normal path
  row_t script [SCRIPT_LEN] = '{
    '{shf_pkg::OP_TICK,       1'b0, 1'b1, {S_IDLE, 6'b000000, shf_pkg::CAUSE_NONE}},
    '{shf_pkg::OP_CONN_RESP,  1'b1, 1'b1, {S_IDLE, 6'b000000, shf_pkg::CAUSE_NONE}},
    '{shf_pkg::OP_CTX_SETUP,  1'b0, 1'b0, '0},
    '{shf_pkg::OP_CTX_READY,  1'b1, 1'b0, '0},
    '{shf_pkg::OP_PEER_DISC,  1'b0, 1'b0, '0},
    '{OP_RESERVED,            1'b1, 1'b1, {S_IDLE, 6'b000000, shf_pkg::CAUSE_NONE}},
    '{shf_pkg::OP_SETUP,      1'b1, 1'b1, {S_WAIT_CONN, 6'b100000, shf_pkg::CAUSE_NONE}},
    '{shf_pkg::OP_SETUP,      1'b0, 1'b1, {S_WAIT_CONN, 6'b000000, shf_pkg::CAUSE_NONE}},
    '{shf_pkg::OP_TICK,       1'b1, 1'b0, '0},
    '{shf_pkg::OP_CTX_READY,  1'b0, 1'b0, '0},
    '{shf_pkg::OP_LOCAL_DISC, 1'b1, 1'b0, '0},
    '{shf_pkg::OP_PEER_DISC,  1'b0, 1'b0, '0},
    '{shf_pkg::OP_CONN_RESP,  1'b0, 1'b1, {S_CONNECTED, 6'b000100, shf_pkg::CAUSE_NONE}},
    '{shf_pkg::OP_TICK,       1'b0, 1'b0, '0},
    '{shf_pkg::OP_SETUP,      1'b1, 1'b0, '0},
    '{shf_pkg::OP_CTX_READY,  1'b1, 1'b0, '0},
    '{shf_pkg::OP_CTX_SETUP,  1'b0, 1'b0, '0},
    '{shf_pkg::OP_TICK,       1'b1, 1'b0, '0},
    '{shf_pkg::OP_CTX_SETUP,  1'b1, 1'b0, '0},
    '{OP_RESERVED,            1'b0, 1'b0, '0},
    '{shf_pkg::OP_CTX_READY,  1'b0, 1'b0, '0},
    '{shf_pkg::OP_TICK,       1'b0, 1'b0, '0},
    '{shf_pkg::OP_CONN_RESP,  1'b1, 1'b0, '0},
    '{shf_pkg::OP_CTX_SETUP,  1'b0, 1'b0, '0}
  };

  session_handshake_fsm_unit uut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_operation             (in_operation),
    .in_version_ok            (in_version_ok),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_status               (out_status),
    .out_send_connect         (out_send_connect),
    .out_send_disconnect      (out_send_disconnect),
    .out_send_context_setup   (out_send_context_setup),
    .out_notify_connected     (out_notify_connected),
    .out_notify_context_ready (out_notify_context_ready),
    .out_notify_disconnected  (out_notify_disconnected),
    .out_disconnect_cause     (out_disconnect_cause)
  );

  always #1 clk = ~clk;

  // session teardown: timer always disarmed
  function automatic void end_session(inout shf_pkg::result_t r,
                                      input shf_pkg::cause_t why,
                                      input logic tell_peer);
    sess = S_DISC;
    tmr_on = 1'b0;
    tmr_left = '0;
    r.send_disconnect = tell_peer;
    r.notify_disconnected = 1'b1;
    r.cause = why;
  endfunction

  // advance the session model by one event and return its result
  function automatic shf_pkg::result_t step_session(input logic [2:0] op, input logic ver);
    shf_pkg::result_t r;
    logic             fired;
    r = '0;
    fired = 1'b0;
    // countdown on ticks; a count of one or less fires and disarms
    if (sess != S_DISC && op == shf_pkg::OP_TICK && tmr_on) begin
      if (tmr_left <= 1) begin
        tmr_left = '0;
        tmr_on = 1'b0;
        fired = 1'b1;
      end else begin
        tmr_left = tmr_left - 1'b1;
      end
    end
    case (sess)
      S_IDLE: begin
        if (op == shf_pkg::OP_SETUP && !ver) begin
          end_session(r, shf_pkg::CAUSE_VERSION, 1'b1);
        end else if (op == shf_pkg::OP_SETUP) begin
          sess = S_WAIT_CONN;
          tmr_left = connect_tmo;
          tmr_on = 1'b1;
          r.send_connect = 1'b1;
        end else if (op == shf_pkg::OP_LOCAL_DISC) begin
          end_session(r, shf_pkg::CAUSE_LOCAL, 1'b1);
        end
      end
      S_WAIT_CONN: begin
        if (op == shf_pkg::OP_CONN_RESP) begin
          tmr_on = 1'b0;
          tmr_left = '0;
          sess = S_CONNECTED;
          r.notify_connected = 1'b1;
        end else if (fired) begin
          end_session(r, shf_pkg::CAUSE_CONN_TMO, 1'b0);
        end
      end
      S_CONNECTED: begin
        if (op == shf_pkg::OP_CTX_SETUP) begin
          sess = S_WAIT_CTX;
          tmr_left = context_tmo;
          tmr_on = 1'b1;
          r.send_context_setup = 1'b1;
        end else if (op == shf_pkg::OP_LOCAL_DISC) begin
          end_session(r, shf_pkg::CAUSE_LOCAL, 1'b1);
        end else if (op == shf_pkg::OP_PEER_DISC) begin
          end_session(r, shf_pkg::CAUSE_PEER, 1'b0);
        end
      end
      S_WAIT_CTX: begin
        if (fired) begin
          end_session(r, shf_pkg::CAUSE_CTX_TMO, 1'b0);
        end else if (op == shf_pkg::OP_CTX_SETUP) begin
          tmr_left = context_tmo;
          tmr_on = 1'b1;
          r.send_context_setup = 1'b1;
        end else if (op == shf_pkg::OP_CTX_READY) begin
          tmr_on = 1'b0;
          tmr_left = '0;
          sess = S_READY;
          r.notify_context_ready = 1'b1;
        end else if (op == shf_pkg::OP_PEER_DISC) begin
          end_session(r, shf_pkg::CAUSE_PEER, 1'b0);
        end else if (op == shf_pkg::OP_LOCAL_DISC) begin
          end_session(r, shf_pkg::CAUSE_LOCAL, 1'b1);
        end
      end
      S_READY: begin
        if (op == shf_pkg::OP_CTX_SETUP) begin
          sess = S_WAIT_CTX;
          tmr_left = context_tmo;
          tmr_on = 1'b1;
          r.send_context_setup = 1'b1;
        end else if (op == shf_pkg::OP_PEER_DISC) begin
          end_session(r, shf_pkg::CAUSE_PEER, 1'b0);
        end else if (op == shf_pkg::OP_LOCAL_DISC) begin
          end_session(r, shf_pkg::CAUSE_LOCAL, 1'b1);
        end
      end
      default: ;
    endcase
    r.status = sess;
    return r;
  endfunction

  // random event, mostly the next step of a healthy session; unless the
  // session may close, anything that would tear it down is redrawn
  function automatic void pick_event(input logic may_close, output logic [2:0] op,
                                     output logic ver);
    session_t                       s_save;
    logic [shf_pkg::TIMER_BITS-1:0] t_save;
    logic                           on_save;
    shf_pkg::result_t               trial;
    logic                           closes;
    ver = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 6) begin
      case (sess)
        S_IDLE:               op = shf_pkg::OP_SETUP;
        S_WAIT_CONN:          op = shf_pkg::OP_CONN_RESP;
        S_CONNECTED, S_READY: op = shf_pkg::OP_CTX_SETUP;
        S_WAIT_CTX: begin
          op = ($urandom_range(0, 3) != 0) ? shf_pkg::OP_TICK : shf_pkg::OP_CTX_READY;
        end
        default:              op = 3'($urandom_range(0, 7));
      endcase
    end else begin
      op = 3'($urandom_range(0, 7));
    end
    closes = 1'b1;
    while (!may_close && closes) begin
      s_save = sess;
      t_save = tmr_left;
      on_save = tmr_on;
      trial = step_session(op, ver);
      sess = s_save;
      tmr_left = t_save;
      tmr_on = on_save;
      closes = (s_save != S_DISC) && trial.notify_disconnected;
      if (closes) begin
        op = 3'($urandom_range(0, 7));
        ver = 1'b1;
      end
    end
  endfunction

  function automatic void check_field(input string fname, input logic [2:0] want,
                                      input logic [2:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, fname, want, got);
      failed = 1'b1;
    end
  endfunction

  // offer one event, hold it until taken, then record the expected result
  task automatic send_event(input logic [2:0] op, input logic ver, input logic typed,
                            input shf_pkg::result_t typed_res);
    shf_pkg::result_t r;
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_version_ok <= ver;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = step_session(op, ver);
    pending_results.push_back(typed ? typed_res : r);
    events_in++;
    @(negedge clk);
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // write both timeouts, optionally also the undecoded index
  task automatic set_timeouts(input logic [shf_pkg::CFG_BITS-1:0] conn,
                              input logic [shf_pkg::CFG_BITS-1:0] ctx,
                              input logic poke_unused);
    cfg_we <= 1'b1;
    cfg_index <= shf_pkg::REG_CONNECT_TMO;
    cfg_data <= conn;
    @(negedge clk);
    cfg_index <= shf_pkg::REG_CONTEXT_TMO;
    cfg_data <= ctx;
    @(negedge clk);
    connect_tmo = conn;
    context_tmo = ctx;
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data <= shf_pkg::CFG_BITS'($urandom);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    shf_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result transaction, status %0d", $time, out_status);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("send_connect", 3'(want.send_connect), 3'(out_send_connect));
        check_field("send_disconnect", 3'(want.send_disconnect),
                    3'(out_send_disconnect));
        check_field("send_context_setup", 3'(want.send_context_setup),
                    3'(out_send_context_setup));
        check_field("notify_connected", 3'(want.notify_connected),
                    3'(out_notify_connected));
        check_field("notify_context_ready", 3'(want.notify_context_ready),
                    3'(out_notify_context_ready));
        check_field("notify_disconnected", 3'(want.notify_disconnected),
                    3'(out_notify_disconnected));
        check_field("disconnect_cause", want.cause, out_disconnect_cause);
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off to fill the block
  initial begin
    int   stall_left;
    logic hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && events_in >= HOLD_AT) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rx_gaps && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [2:0] op;
    logic       ver;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = shf_pkg::REG_CONNECT_TMO;
    cfg_data = '0;
    in_valid = 1'b0;
    in_operation = shf_pkg::OP_TICK;
    in_version_ok = 1'b0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    sess = S_IDLE;
    tmr_left = '0;
    tmr_on = 1'b0;
    connect_tmo = shf_pkg::CONNECT_TMO_RESET;
    context_tmo = shf_pkg::CONTEXT_TMO_RESET;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // scripted walk through the session with reset timeouts
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_event(script[i].op, script[i].ver, script[i].typed, script[i].res);
    end
    drain_results();

    // live session under changing timeouts; extremes first
    for (int p = 0; p < PHASES; p++) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      if (p == 0) begin
        set_timeouts('0, '1, 1'b0);
      end else if (p == 1) begin
        set_timeouts('1, shf_pkg::CFG_BITS'(1), 1'b1);
      end else begin
        set_timeouts(shf_pkg::CFG_BITS'($urandom),
                     shf_pkg::CFG_BITS'($urandom_range(2, 40)), p == 2);
      end
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        pick_event(1'b0, op, ver);
        send_event(op, ver, 1'b0, '0);
      end
      drain_results();
    end

    // closing part: no idling, the session may end and then absorbs events
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    set_timeouts(shf_pkg::CFG_BITS'($urandom),
                 shf_pkg::CFG_BITS'($urandom_range(0, 3)), 1'b0);
    for (int n = 0; n < PHASE_EVENTS; n++) begin
      pick_event(1'b1, op, ver);
      send_event(op, ver, 1'b0, '0);
    end
    drain_results();
    repeat (4) @(posedge clk);

    if (failed || pending_results.size() != 0) begin
      $display("Verification failed");
    end else begin
      $display("Verification passed");
    end
    $finish;
  end

endmodule

`default_nettype wire
